### hw/rtl/knn_background_subtract_pixel_unit_defines.svh
`ifndef KNN_BACKGROUND_SUBTRACT_PIXEL_UNIT_DEFINES_SVH
`define KNN_BACKGROUND_SUBTRACT_PIXEL_UNIT_DEFINES_SVH

// Checks in the clk domain, quiet while arst_n is low.
`define KNNBG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define KNNBG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/knnbg_pkg.sv
`timescale 1ns / 1ps

package knnbg_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int HIST_DEPTH = 7;

	localparam int GRAY_W   = 8;
	localparam int DIM_W    = 9;
	localparam int DIST_W   = 9;
	localparam int THRESH_W = 3;
	localparam int LOCS     = MAX_WIDTH * MAX_HEIGHT;
	localparam int LOC_W    = $clog2(LOCS);
	localparam int CNT_W    = LOC_W + 1;
	localparam int SLOT_W   = $clog2(HIST_DEPTH);
	localparam int VOTE_W   = $clog2(HIST_DEPTH + 1);

	// one history word per pixel location
	typedef struct packed {
		logic [HIST_DEPTH-1:0]             flags;
		logic [HIST_DEPTH-1:0][GRAY_W-1:0] grays;
	} hist_t;

	localparam int HIST_W = $bits(hist_t);

	typedef struct packed {
		logic is_fg;
		logic new_flag;
	} vote_t;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_MATCH_DIST   = 2'd2,
		REG_VOTE_THRESH  = 2'd3
	} reg_t;

endpackage

### hw/rtl/knnbg_hist_ram.sv
`timescale 1ns / 1ps

module knnbg_hist_ram #(
	parameter int DATA_W = 64,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// old data on a same-address collision; the caller forwards
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/knnbg_vote.sv
`timescale 1ns / 1ps

module knnbg_vote (
	input  logic [knnbg_pkg::GRAY_W-1:0]   gray,
	input  knnbg_pkg::hist_t               hist,
	input  logic [knnbg_pkg::SLOT_W-1:0]   slot,
	input  logic [knnbg_pkg::DIST_W-1:0]   match_distance,
	input  logic [knnbg_pkg::THRESH_W-1:0] vote_threshold,
	output knnbg_pkg::hist_t               hist_new,
	output knnbg_pkg::vote_t               vote
);

	logic [knnbg_pkg::HIST_DEPTH-1:0] hit;
	logic [knnbg_pkg::VOTE_W-1:0]     match_cnt;
	logic [knnbg_pkg::VOTE_W-1:0]     flagged;
	logic [knnbg_pkg::VOTE_W-1:0]     thresh;

	always_comb begin
		logic [knnbg_pkg::GRAY_W-1:0] diff;
		for (int n = 0; n < knnbg_pkg::HIST_DEPTH; n++) begin
			diff = (gray >= hist.grays[n]) ? gray - hist.grays[n] : hist.grays[n] - gray;
			hit[n] = {1'b0, diff} < match_distance;
		end
	end

	always_comb begin
		match_cnt = '0;
		flagged   = '0;
		for (int n = 0; n < knnbg_pkg::HIST_DEPTH; n++) begin
			match_cnt = match_cnt + knnbg_pkg::VOTE_W'(hit[n]);
			flagged   = flagged + knnbg_pkg::VOTE_W'(hit[n] & hist.flags[n]);
		end
	end

	assign thresh = knnbg_pkg::VOTE_W'(vote_threshold);

	assign vote.is_fg    = flagged < thresh;
	assign vote.new_flag = match_cnt >= thresh;

	always_comb begin
		hist_new = hist;
		hist_new.grays[slot] = gray;
		hist_new.flags[slot] = vote.new_flag;
	end

endmodule

### hw/rtl/knn_background_subtract_pixel_unit.sv
`timescale 1ns / 1ps
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------
// pixel in  | pixel_valid / pixel_ready  | pixel_gray
// result    | result_valid / result_ready| is_foreground, end_of_frame
// config    | APB psel/penable/pwrite    | paddr[3:2] index, pwdata
//
// One pixel per clock sustained while results are taken. Accept cycle reads
// the history word of the location from one RAM port; the vote stage votes
// and writes it back on the other port, with forwarding when a one-pixel
// frame hits the same entry. result_valid comes from the result word register.
// No clearing pass: written locations always form a prefix, so a fill count
// marks unwritten words, which read as zero. Reset is ready at once.
// A stalled result holds the vote stage; pixel_ready drops only then.

`include "knn_background_subtract_pixel_unit_defines.svh"

module knn_background_subtract_pixel_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	output logic                         pixel_ready,
	input  logic [knnbg_pkg::GRAY_W-1:0] pixel_gray,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic                         is_foreground,
	output logic                         end_of_frame,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [3:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int LOC_W  = knnbg_pkg::LOC_W;
	localparam int CNT_W  = knnbg_pkg::CNT_W;
	localparam int DIM_W  = knnbg_pkg::DIM_W;
	localparam int SLOT_W = knnbg_pkg::SLOT_W;

	// config registers
	logic [DIM_W-1:0]               width_q;
	logic [DIM_W-1:0]               height_q;
	logic [knnbg_pkg::DIST_W-1:0]   dist_q;
	logic [knnbg_pkg::THRESH_W-1:0] thresh_q;
	logic                           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(256);
			height_q <= DIM_W'(256);
			dist_q   <= knnbg_pkg::DIST_W'(20);
			thresh_q <= knnbg_pkg::THRESH_W'(3);
		end else if (cfg_wr) begin
			unique case (knnbg_pkg::reg_t'(paddr[3:2]))
				knnbg_pkg::REG_FRAME_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				knnbg_pkg::REG_FRAME_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				knnbg_pkg::REG_MATCH_DIST:   dist_q   <= pwdata[knnbg_pkg::DIST_W-1:0];
				knnbg_pkg::REG_VOTE_THRESH:  thresh_q <= pwdata[knnbg_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (knnbg_pkg::reg_t'(paddr[3:2]))
			knnbg_pkg::REG_FRAME_WIDTH:  prdata = 32'(width_q);
			knnbg_pkg::REG_FRAME_HEIGHT: prdata = 32'(height_q);
			knnbg_pkg::REG_MATCH_DIST:   prdata = 32'(dist_q);
			knnbg_pkg::REG_VOTE_THRESH:  prdata = 32'(thresh_q);
			default:                     prdata = '0;
		endcase
	end

	// frame geometry
	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic [2*DIM_W-1:0] prod;
	logic [CNT_W-1:0]   total;

	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (width_q > DIM_W'(knnbg_pkg::MAX_WIDTH)) begin
			w_eff = DIM_W'(knnbg_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (height_q > DIM_W'(knnbg_pkg::MAX_HEIGHT)) begin
			h_eff = DIM_W'(knnbg_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign prod  = w_eff * h_eff;
	assign total = prod[CNT_W-1:0];

	// position tracking at accept
	logic [LOC_W-1:0]  pos_q;
	logic [SLOT_W-1:0] slot_q;
	logic [LOC_W-1:0]  pos_cur;
	logic              last_cur;
	logic              accept;

	assign accept   = pixel_valid & pixel_ready;
	assign pos_cur  = ({1'b0, pos_q} >= total) ? '0 : pos_q;
	assign last_cur = {1'b0, pos_cur} == (total - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (last_cur) begin
				pos_q  <= '0;
				slot_q <= (slot_q == SLOT_W'(knnbg_pkg::HIST_DEPTH - 1)) ? '0
				          : slot_q + SLOT_W'(1);
			end else begin
				pos_q <= pos_cur + LOC_W'(1);
			end
		end
	end

	// vote stage
	logic                         valid_s1;
	logic [knnbg_pkg::GRAY_W-1:0] gray_s1;
	logic [LOC_W-1:0]             addr_s1;
	logic [SLOT_W-1:0]            slot_s1;
	logic                         last_s1;
	logic                         known_s1;
	logic                         fwd_s1;
	knnbg_pkg::hist_t             fwd_word_s1;
	knnbg_pkg::hist_t             rd_word;
	knnbg_pkg::hist_t             hist_cur;
	knnbg_pkg::hist_t             hist_new;
	knnbg_pkg::vote_t             vote;
	logic [CNT_W-1:0]             fill_q;
	logic                         s1_adv;
	logic                         fwd_hit;
	logic                         out_valid_q;

	assign s1_adv      = valid_s1 & (~out_valid_q | result_ready);
	assign pixel_ready = ~valid_s1 | s1_adv;
	assign fwd_hit     = s1_adv & (addr_s1 == pos_cur);

	knnbg_hist_ram #(
		.DATA_W (knnbg_pkg::HIST_W),
		.ADDR_W (LOC_W)
	) u_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (addr_s1),
		.wdata (hist_new),
		.re    (accept),
		.raddr (pos_cur),
		.rdata (rd_word)
	);

	always_comb begin
		if (fwd_s1) begin
			hist_cur = fwd_word_s1;
		end else if (known_s1) begin
			hist_cur = rd_word;
		end else begin
			hist_cur = '0;
		end
	end

	knnbg_vote u_vote (
		.gray           (gray_s1),
		.hist           (hist_cur),
		.slot           (slot_s1),
		.match_distance (dist_q),
		.vote_threshold (thresh_q),
		.hist_new       (hist_new),
		.vote           (vote)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1     <= pixel_gray;
			addr_s1     <= pos_cur;
			slot_s1     <= slot_q;
			last_s1     <= last_cur;
			fwd_s1      <= fwd_hit;
			fwd_word_s1 <= hist_new;
			known_s1    <= fwd_hit | ({1'b0, pos_cur} < fill_q);
		end
	end

	// written locations are a prefix; grow it when the word at its edge lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (s1_adv && ({1'b0, addr_s1} == fill_q)) begin
			fill_q <= fill_q + CNT_W'(1);
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			is_foreground <= vote.is_fg;
			end_of_frame  <= last_s1;
		end
	end

	assign result_valid = out_valid_q;

	`KNNBG_ASSERT_IMP(a_wr_in_prefix, s1_adv, {1'b0, addr_s1} <= fill_q,
		"history write outside the written prefix")
	`KNNBG_ASSERT_IMP(a_stall_cause, !pixel_ready,
		valid_s1 && out_valid_q && !result_ready, "input stalled without a held result")
	`KNNBG_ASSERT_NXT(a_adv_shows, s1_adv, result_valid,
		"vote stage advanced but no result word shown")

endmodule
